// ===== rtl/ncs_pkg.sv =====
// Shared types, constants and saturation helpers for the cubic spline block.
`default_nettype none
package ncs_pkg;

    localparam int unsigned MAX_POINTS = 16;

    localparam int unsigned CRD_W = 32;
    localparam int unsigned ACC_W = 48;
    localparam int unsigned WIDE_W = 52;
    localparam int unsigned FAC_W = 24;
    localparam int unsigned T_W = 17;
    localparam int unsigned SEG_W = 4;
    localparam int unsigned DEN_W = 26;
    localparam int unsigned MUL_LAT = 3;

    localparam logic [FAC_W-1:0] FACTOR_FIRST = 24'h800000;
    localparam logic [T_W-1:0] T_ONE = 17'h10000;
    localparam logic [DEN_W:0] DEN_MID = 27'h4000000;
    localparam logic [DEN_W:0] DEN_LAST = 27'h2000000;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_SPLINE = 2'd1,
        ST_BAD_SEG   = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        LOP_NONE,
        LOP_FW_CAP,
        LOP_FW_START,
        LOP_FW_WRITE,
        LOP_BS_CAP,
        LOP_BS_CAPB,
        LOP_BS_SLOPE,
        LOP_BS_COEF,
        LOP_EV_START0,
        LOP_EV_ACC_B,
        LOP_EV_ACC_C,
        LOP_EV_START,
        LOP_EV_FIN
    } t_lop;

    typedef struct packed {
        t_lop op;
        logic first;
    } t_lane_ctl;

    typedef struct packed {
        logic              req_type;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic              last_point;
        logic [3:0]        segment;
        logic [16:0]       param_t;
    } t_in;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic [1:0]         status;
    } t_out;

    function automatic logic signed [ACC_W-1:0] f_sat48(input logic signed [WIDE_W-1:0] v);
        if (v[WIDE_W-1:ACC_W-1] == '0 || v[WIDE_W-1:ACC_W-1] == '1) begin
            return v[ACC_W-1:0];
        end else if (v[WIDE_W-1]) begin
            return {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            return {1'b0, {(ACC_W-1){1'b1}}};
        end
    endfunction

    function automatic logic signed [CRD_W-1:0] f_sat32(input logic signed [WIDE_W-1:0] v);
        if (v[WIDE_W-1:CRD_W-1] == '0 || v[WIDE_W-1:CRD_W-1] == '1) begin
            return v[CRD_W-1:0];
        end else if (v[WIDE_W-1]) begin
            return {1'b1, {(CRD_W-1){1'b0}}};
        end else begin
            return {1'b0, {(CRD_W-1){1'b1}}};
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/ncs_ram.sv =====
// Generic single write port RAM with registered read.
`default_nettype none
module ncs_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/ncs_recip.sv =====
// Bit-serial reciprocal unit for the sweep factors: round(2^48 / den).
`default_nettype none
module ncs_recip (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [ncs_pkg::DEN_W-1:0]   i_den,
    output logic                             o_done,
    output logic      [ncs_pkg::FAC_W-1:0]   o_q
);
    localparam int unsigned DW = ncs_pkg::DEN_W;
    localparam int unsigned QW = ncs_pkg::FAC_W;

    logic          r_busy;
    logic          r_done;
    logic [4:0]    r_cnt;
    logic [DW-1:0] r_den;
    logic [DW-1:0] r_rem;
    logic [QW-1:0] r_low;
    logic [QW-1:0] r_q;
    logic [DW:0]   w_trial;
    logic          w_ge;

    assign w_trial = {r_rem, r_low[QW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_den  <= i_den;
                // dividend is 2^48 + den/2; top bits seed the remainder
                r_rem  <= {2'b01, {(DW-3){1'b0}}, i_den[DW-1]};
                r_low  <= i_den[QW:1];
                r_q    <= '0;
            end else if (r_busy) begin
                r_rem <= w_ge ? DW'(w_trial - {1'b0, r_den}) : DW'(w_trial);
                r_low <= {r_low[QW-2:0], 1'b0};
                r_q   <= {r_q[QW-2:0], w_ge};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;
endmodule
`default_nettype wire

// ===== rtl/ncs_mulfrac.sv =====
// Signed by unsigned fractional multiply, rounded half away from zero.
`default_nettype none
module ncs_mulfrac (
    input  wire logic                              i_clk,
    input  wire logic                              i_start,
    input  wire logic signed [ncs_pkg::ACC_W-1:0]  i_x,
    input  wire logic        [ncs_pkg::FAC_W-1:0]  i_f,
    input  wire logic                              i_sh16,
    output logic signed      [ncs_pkg::ACC_W-1:0]  o_r
);
    localparam int unsigned AW = ncs_pkg::ACC_W;
    localparam int unsigned FW = ncs_pkg::FAC_W;
    localparam int unsigned HW = AW / 2;
    localparam int unsigned PW = AW + FW;

    logic                 r_neg;
    logic                 r_sh16;
    logic [AW-1:0]        r_m;
    logic [FW-1:0]        r_f;
    logic [HW+FW-1:0]     r_plo;
    logic [HW+FW-1:0]     r_phi;
    logic signed [AW-1:0] r_r;
    logic [AW-1:0]        w_mag_in;
    logic [PW-1:0]        w_p;
    logic [PW-1:0]        w_rnd;
    logic [AW-1:0]        w_mag;

    assign w_mag_in = i_x[AW-1] ? AW'(-i_x) : AW'(i_x);
    assign w_p      = {r_phi, {HW{1'b0}}} + PW'(r_plo);
    assign w_rnd    = r_sh16 ? ((w_p + PW'(1 << 15)) >> 16) : ((w_p + PW'(1 << 23)) >> 24);
    assign w_mag    = w_rnd[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg  <= i_x[AW-1];
            r_m    <= w_mag_in;
            r_f    <= i_f;
            r_sh16 <= i_sh16;
        end
        r_plo <= r_m[HW-1:0] * r_f;
        r_phi <= r_m[AW-1:HW] * r_f;
        r_r   <= r_neg ? -$signed(w_mag) : $signed(w_mag);
    end

    assign o_r = r_r;
endmodule
`default_nettype wire

// ===== rtl/ncs_lane.sv =====
// One axis lane: point and coefficient stores, sweep, substitution and Horner datapath.
`default_nettype none
module ncs_lane #(
    parameter int unsigned MAX_POINTS = ncs_pkg::MAX_POINTS,
    localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
    input  wire logic                              i_clk,
    input  wire ncs_pkg::t_lane_ctl                i_ctl,
    input  wire logic                              i_pt_we,
    input  wire logic [AW-1:0]                     i_pt_waddr,
    input  wire logic signed [ncs_pkg::CRD_W-1:0]  i_pt_wdata,
    input  wire logic [AW-1:0]                     i_pt_raddr,
    input  wire logic [AW-1:0]                     i_co_addr,
    input  wire logic [ncs_pkg::FAC_W-1:0]         i_factor,
    input  wire logic [ncs_pkg::T_W-1:0]           i_t,
    output logic signed [ncs_pkg::CRD_W-1:0]       o_res
);
    localparam int unsigned CW = ncs_pkg::CRD_W;
    localparam int unsigned DW = ncs_pkg::ACC_W;
    localparam int unsigned WW = ncs_pkg::WIDE_W;

    logic signed [CW-1:0] w_pt_rd;
    logic signed [DW-1:0] w_sl_rd;
    logic signed [DW-1:0] w_cu_rd;
    logic signed [DW-1:0] w_sq_rd;
    logic signed [DW-1:0] w_mul;

    logic signed [CW-1:0] r_pa;
    logic signed [CW-1:0] r_pb;
    logic signed [DW-1:0] r_sprev;
    logic signed [DW-1:0] r_sfw;
    logic signed [DW-1:0] r_scur;
    logic signed [DW-1:0] r_acc;
    logic signed [CW-1:0] r_res;

    logic                  w_sl_we;
    logic signed [DW-1:0]  w_sl_wdata;
    logic                  w_co_we;
    logic signed [CW:0]    w_dy_fw;
    logic signed [CW:0]    w_dy_bs;
    logic signed [WW-1:0]  w_rhs;
    logic signed [DW-1:0]  w_snew;
    logic signed [DW-1:0]  w_coef_a;
    logic signed [DW-1:0]  w_coef_b;
    logic                  w_mstart;
    logic signed [DW-1:0]  w_mx;
    logic [ncs_pkg::FAC_W-1:0] w_mf;
    logic                  w_msh16;

    assign w_dy_fw = (CW+1)'(r_pa) - (CW+1)'(w_pt_rd);
    assign w_dy_bs = (CW+1)'(r_pa) - (CW+1)'(r_pb);
    assign w_rhs   = WW'(w_dy_fw) * 3 - (i_ctl.first ? WW'(0) : WW'(r_sprev));
    assign w_snew  = ncs_pkg::f_sat48(WW'(r_sfw) - WW'(w_mul));
    assign w_coef_a = ncs_pkg::f_sat48(WW'(r_scur) + WW'(r_sprev) - WW'(w_dy_bs) * 2);
    assign w_coef_b = ncs_pkg::f_sat48(WW'(w_dy_bs) * 3 - WW'(r_scur) * 2 - WW'(r_sprev));

    assign w_sl_we    = (i_ctl.op == ncs_pkg::LOP_FW_WRITE) || (i_ctl.op == ncs_pkg::LOP_BS_SLOPE);
    assign w_sl_wdata = (i_ctl.op == ncs_pkg::LOP_FW_WRITE) ? w_mul : w_snew;
    assign w_co_we    = (i_ctl.op == ncs_pkg::LOP_BS_COEF);

    always_comb begin
        w_mstart = 1'b0;
        w_mx     = r_acc;
        w_mf     = i_factor;
        w_msh16  = 1'b0;
        case (i_ctl.op)
            ncs_pkg::LOP_FW_START: begin
                w_mstart = 1'b1;
                w_mx     = ncs_pkg::f_sat48(w_rhs);
            end
            ncs_pkg::LOP_BS_CAP: begin
                w_mstart = 1'b1;
                w_mx     = r_sprev;
            end
            ncs_pkg::LOP_EV_START0: begin
                w_mstart = 1'b1;
                w_mx     = w_cu_rd;
                w_mf     = ncs_pkg::FAC_W'(i_t);
                w_msh16  = 1'b1;
            end
            ncs_pkg::LOP_EV_START: begin
                w_mstart = 1'b1;
                w_mf     = ncs_pkg::FAC_W'(i_t);
                w_msh16  = 1'b1;
            end
            default: begin
                w_mstart = 1'b0;
            end
        endcase
    end

    ncs_mulfrac u_mul (
        .i_clk   (i_clk),
        .i_start (w_mstart),
        .i_x     (w_mx),
        .i_f     (w_mf),
        .i_sh16  (w_msh16),
        .o_r     (w_mul)
    );

    ncs_ram #(.WIDTH(CW), .DEPTH(MAX_POINTS)) u_pt (
        .i_clk   (i_clk),
        .i_we    (i_pt_we),
        .i_waddr (i_pt_waddr),
        .i_wdata (i_pt_wdata),
        .i_raddr (i_pt_raddr),
        .o_rdata (w_pt_rd)
    );

    ncs_ram #(.WIDTH(DW), .DEPTH(MAX_POINTS)) u_slope (
        .i_clk   (i_clk),
        .i_we    (w_sl_we),
        .i_waddr (i_co_addr),
        .i_wdata (w_sl_wdata),
        .i_raddr (i_co_addr),
        .o_rdata (w_sl_rd)
    );

    ncs_ram #(.WIDTH(DW), .DEPTH(MAX_POINTS)) u_cubic (
        .i_clk   (i_clk),
        .i_we    (w_co_we),
        .i_waddr (i_co_addr),
        .i_wdata (w_coef_a),
        .i_raddr (i_co_addr),
        .o_rdata (w_cu_rd)
    );

    ncs_ram #(.WIDTH(DW), .DEPTH(MAX_POINTS)) u_square (
        .i_clk   (i_clk),
        .i_we    (w_co_we),
        .i_waddr (i_co_addr),
        .i_wdata (w_coef_b),
        .i_raddr (i_co_addr),
        .o_rdata (w_sq_rd)
    );

    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            ncs_pkg::LOP_FW_CAP: begin
                r_pa <= w_pt_rd;
            end
            ncs_pkg::LOP_FW_WRITE: begin
                r_sprev <= w_mul;
            end
            ncs_pkg::LOP_BS_CAP: begin
                r_sfw <= w_sl_rd;
                r_pa  <= w_pt_rd;
            end
            ncs_pkg::LOP_BS_CAPB: begin
                r_pb <= w_pt_rd;
            end
            ncs_pkg::LOP_BS_SLOPE: begin
                r_scur <= w_snew;
            end
            ncs_pkg::LOP_BS_COEF: begin
                r_sprev <= r_scur;
            end
            ncs_pkg::LOP_EV_ACC_B: begin
                r_acc <= ncs_pkg::f_sat48(WW'(w_mul) + WW'(w_sq_rd));
            end
            ncs_pkg::LOP_EV_ACC_C: begin
                r_acc <= ncs_pkg::f_sat48(WW'(w_mul) + WW'(w_sl_rd));
            end
            ncs_pkg::LOP_EV_FIN: begin
                r_res <= ncs_pkg::f_sat32(WW'(w_mul) + WW'(w_pt_rd));
            end
            default: begin
            end
        endcase
    end

    assign o_res = r_res;
endmodule
`default_nettype wire

// ===== rtl/natural_cubic_spline_fit_eval.sv =====
// Three-axis natural cubic spline: point loading, fit sequencer, evaluation and result merge.
//
// Input channel (i_in_valid / o_in_ready / i_in_data) takes load and evaluate items.
// Output channel (o_out_valid / i_out_ready / o_out_data) returns one result per
// evaluate item; loads return nothing. A transfer happens when valid and ready are high.
// One item is worked on at a time; o_in_ready is high only while the sequencer is idle.
// The load carrying last_point with n >= 2 points runs the fit: a bit-serial
// reciprocal for each of the n - 1 computed sweep factors, then the forward sweep
// (n rows) and the back substitution (n - 1 rows).
// An evaluate runs three Horner steps on the multiplier of each lane, then loads the
// output register; a status-only result skips the Horner steps.
// The three axis lanes run in lock-step; the output register merges their results.
// A result waiting in the output register does not block new input until another
// evaluate finishes and finds the register still full; it then waits for i_out_ready.
// Reset (i_rst_n low, synchronous) drops any spline and point count and empties the
// output register. Stores are not cleared; only entries written by loads and the fit are read.
`default_nettype none
module natural_cubic_spline_fit_eval #(
    parameter int unsigned MAX_POINTS = ncs_pkg::MAX_POINTS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire ncs_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output ncs_pkg::t_out      o_out_data
);
    localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
    localparam int unsigned SUB_W = 5;
    localparam int unsigned L = ncs_pkg::MUL_LAT;

    localparam logic [SUB_W-1:0] SUB_FW_CAP    = SUB_W'(1);
    localparam logic [SUB_W-1:0] SUB_FW_START  = SUB_W'(2);
    localparam logic [SUB_W-1:0] SUB_FW_WRITE  = SUB_W'(2 + L);
    localparam logic [SUB_W-1:0] SUB_BS_CAP    = SUB_W'(1);
    localparam logic [SUB_W-1:0] SUB_BS_CAPB   = SUB_W'(2);
    localparam logic [SUB_W-1:0] SUB_BS_SLOPE  = SUB_W'(1 + L);
    localparam logic [SUB_W-1:0] SUB_BS_COEF   = SUB_W'(2 + L);
    localparam logic [SUB_W-1:0] SUB_EV_START0 = SUB_W'(1);
    localparam logic [SUB_W-1:0] SUB_EV_ACC_B  = SUB_W'(1 + L);
    localparam logic [SUB_W-1:0] SUB_EV_START1 = SUB_W'(2 + L);
    localparam logic [SUB_W-1:0] SUB_EV_ACC_C  = SUB_W'(2 + 2 * L);
    localparam logic [SUB_W-1:0] SUB_EV_START2 = SUB_W'(3 + 2 * L);
    localparam logic [SUB_W-1:0] SUB_EV_FIN    = SUB_W'(3 + 3 * L);

    typedef enum logic [2:0] {
        S_IDLE,
        S_F0,
        S_FSTART,
        S_FDIV,
        S_FW,
        S_BS,
        S_EV,
        S_OUT
    } t_state;

    t_state                  r_state;
    logic [SUB_W-1:0]        r_sub;
    logic [AW-1:0]           r_idx;
    logic [CNT_W-1:0]        r_count;
    logic                    r_spline;
    logic [ncs_pkg::FAC_W-1:0] r_fprev;
    logic [ncs_pkg::SEG_W-1:0] r_seg;
    logic [ncs_pkg::T_W-1:0]   r_t;
    ncs_pkg::t_status        r_stat;
    logic                    r_out_valid;
    ncs_pkg::t_out           r_out;

    logic                    w_accept;
    logic [CNT_W-1:0]        w_eff_cnt;
    logic                    w_room;
    logic [CNT_W-1:0]        w_new_cnt;
    logic [AW-1:0]           w_last;
    logic [ncs_pkg::DEN_W-1:0] w_den;
    logic                    w_div_start;
    logic                    w_div_done;
    logic [ncs_pkg::FAC_W-1:0] w_div_q;
    logic                    w_fac_we;
    logic [AW-1:0]           w_fac_waddr;
    logic [ncs_pkg::FAC_W-1:0] w_fac_wdata;
    logic [ncs_pkg::FAC_W-1:0] w_fac_rd;
    ncs_pkg::t_lane_ctl      w_ctl;
    logic [AW-1:0]           w_pt_raddr;
    logic [AW-1:0]           w_co_addr;
    logic                    w_pt_we;
    logic                    w_out_free;
    logic signed [ncs_pkg::CRD_W-1:0] w_res_x;
    logic signed [ncs_pkg::CRD_W-1:0] w_res_y;
    logic signed [ncs_pkg::CRD_W-1:0] w_res_z;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_eff_cnt  = r_spline ? '0 : r_count;
    assign w_room     = (w_eff_cnt < CNT_W'(MAX_POINTS));
    assign w_new_cnt  = w_room ? w_eff_cnt + CNT_W'(1) : w_eff_cnt;
    assign w_pt_we    = w_accept && !i_in_data.req_type && w_room;
    assign w_last     = AW'(r_count - CNT_W'(1));
    assign w_out_free = !r_out_valid || i_out_ready;

    assign w_den = ncs_pkg::DEN_W'(((r_idx == w_last) ? ncs_pkg::DEN_LAST : ncs_pkg::DEN_MID)
                                   - (ncs_pkg::DEN_W+1)'(r_fprev));
    assign w_div_start = (r_state == S_FSTART);

    always_comb begin
        w_fac_we    = 1'b0;
        w_fac_waddr = r_idx;
        w_fac_wdata = w_div_q;
        if (r_state == S_F0) begin
            w_fac_we    = 1'b1;
            w_fac_waddr = '0;
            w_fac_wdata = ncs_pkg::FACTOR_FIRST;
        end else if (r_state == S_FDIV && w_div_done) begin
            w_fac_we = 1'b1;
        end
    end

    always_comb begin
        w_ctl.op    = ncs_pkg::LOP_NONE;
        w_ctl.first = (r_idx == '0);
        w_pt_raddr  = r_idx;
        w_co_addr   = r_idx;
        case (r_state)
            S_FW: begin
                if (r_sub == '0) begin
                    w_pt_raddr = (r_idx == w_last) ? r_idx : r_idx + AW'(1);
                end else begin
                    w_pt_raddr = (r_idx == '0) ? r_idx : r_idx - AW'(1);
                end
                if (r_sub == SUB_FW_CAP) begin
                    w_ctl.op = ncs_pkg::LOP_FW_CAP;
                end else if (r_sub == SUB_FW_START) begin
                    w_ctl.op = ncs_pkg::LOP_FW_START;
                end else if (r_sub == SUB_FW_WRITE) begin
                    w_ctl.op = ncs_pkg::LOP_FW_WRITE;
                end
            end
            S_BS: begin
                w_pt_raddr = (r_sub == '0) ? r_idx + AW'(1) : r_idx;
                if (r_sub == SUB_BS_CAP) begin
                    w_ctl.op = ncs_pkg::LOP_BS_CAP;
                end else if (r_sub == SUB_BS_CAPB) begin
                    w_ctl.op = ncs_pkg::LOP_BS_CAPB;
                end else if (r_sub == SUB_BS_SLOPE) begin
                    w_ctl.op = ncs_pkg::LOP_BS_SLOPE;
                end else if (r_sub == SUB_BS_COEF) begin
                    w_ctl.op = ncs_pkg::LOP_BS_COEF;
                end
            end
            S_EV: begin
                w_pt_raddr = AW'(r_seg);
                w_co_addr  = AW'(r_seg);
                if (r_sub == SUB_EV_START0) begin
                    w_ctl.op = ncs_pkg::LOP_EV_START0;
                end else if (r_sub == SUB_EV_ACC_B) begin
                    w_ctl.op = ncs_pkg::LOP_EV_ACC_B;
                end else if (r_sub == SUB_EV_START1 || r_sub == SUB_EV_START2) begin
                    w_ctl.op = ncs_pkg::LOP_EV_START;
                end else if (r_sub == SUB_EV_ACC_C) begin
                    w_ctl.op = ncs_pkg::LOP_EV_ACC_C;
                end else if (r_sub == SUB_EV_FIN) begin
                    w_ctl.op = ncs_pkg::LOP_EV_FIN;
                end
            end
            default: begin
                w_ctl.op = ncs_pkg::LOP_NONE;
            end
        endcase
    end

    ncs_recip u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_q     (w_div_q)
    );

    ncs_ram #(.WIDTH(ncs_pkg::FAC_W), .DEPTH(MAX_POINTS)) u_factor (
        .i_clk   (i_clk),
        .i_we    (w_fac_we),
        .i_waddr (w_fac_waddr),
        .i_wdata (w_fac_wdata),
        .i_raddr (r_idx),
        .o_rdata (w_fac_rd)
    );

    ncs_lane #(.MAX_POINTS(MAX_POINTS)) u_lane_x (
        .i_clk      (i_clk),
        .i_ctl      (w_ctl),
        .i_pt_we    (w_pt_we),
        .i_pt_waddr (AW'(w_eff_cnt)),
        .i_pt_wdata (i_in_data.point_x),
        .i_pt_raddr (w_pt_raddr),
        .i_co_addr  (w_co_addr),
        .i_factor   (w_fac_rd),
        .i_t        (r_t),
        .o_res      (w_res_x)
    );

    ncs_lane #(.MAX_POINTS(MAX_POINTS)) u_lane_y (
        .i_clk      (i_clk),
        .i_ctl      (w_ctl),
        .i_pt_we    (w_pt_we),
        .i_pt_waddr (AW'(w_eff_cnt)),
        .i_pt_wdata (i_in_data.point_y),
        .i_pt_raddr (w_pt_raddr),
        .i_co_addr  (w_co_addr),
        .i_factor   (w_fac_rd),
        .i_t        (r_t),
        .o_res      (w_res_y)
    );

    ncs_lane #(.MAX_POINTS(MAX_POINTS)) u_lane_z (
        .i_clk      (i_clk),
        .i_ctl      (w_ctl),
        .i_pt_we    (w_pt_we),
        .i_pt_waddr (AW'(w_eff_cnt)),
        .i_pt_wdata (i_in_data.point_z),
        .i_pt_raddr (w_pt_raddr),
        .i_co_addr  (w_co_addr),
        .i_factor   (w_fac_rd),
        .i_t        (r_t),
        .o_res      (w_res_z)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sub       <= '0;
            r_idx       <= '0;
            r_count     <= '0;
            r_spline    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_sub <= '0;
                    if (w_accept) begin
                        if (!i_in_data.req_type) begin
                            r_spline <= 1'b0;
                            if (i_in_data.last_point && w_new_cnt < CNT_W'(2)) begin
                                r_count <= '0;
                            end else begin
                                r_count <= w_new_cnt;
                            end
                            if (i_in_data.last_point && w_new_cnt >= CNT_W'(2)) begin
                                r_state <= S_F0;
                            end
                        end else begin
                            r_seg <= i_in_data.segment;
                            r_t   <= (i_in_data.param_t > ncs_pkg::T_ONE) ?
                                     ncs_pkg::T_ONE : i_in_data.param_t;
                            if (!r_spline) begin
                                r_stat  <= ncs_pkg::ST_NO_SPLINE;
                                r_state <= S_OUT;
                            end else if (10'(i_in_data.segment) + 10'd1 >= 10'(r_count)) begin
                                r_stat  <= ncs_pkg::ST_BAD_SEG;
                                r_state <= S_OUT;
                            end else begin
                                r_stat  <= ncs_pkg::ST_OK;
                                r_state <= S_EV;
                            end
                        end
                    end
                end
                S_F0: begin
                    r_fprev <= ncs_pkg::FACTOR_FIRST;
                    r_idx   <= AW'(1);
                    r_state <= S_FSTART;
                end
                S_FSTART: begin
                    r_state <= S_FDIV;
                end
                S_FDIV: begin
                    if (w_div_done) begin
                        r_fprev <= w_div_q;
                        if (r_idx == w_last) begin
                            r_idx   <= '0;
                            r_sub   <= '0;
                            r_state <= S_FW;
                        end else begin
                            r_idx   <= r_idx + AW'(1);
                            r_state <= S_FSTART;
                        end
                    end
                end
                S_FW: begin
                    if (r_sub == SUB_FW_WRITE) begin
                        r_sub <= '0;
                        if (r_idx == w_last) begin
                            r_idx   <= r_idx - AW'(1);
                            r_state <= S_BS;
                        end else begin
                            r_idx <= r_idx + AW'(1);
                        end
                    end else begin
                        r_sub <= r_sub + SUB_W'(1);
                    end
                end
                S_BS: begin
                    if (r_sub == SUB_BS_COEF) begin
                        r_sub <= '0;
                        if (r_idx == '0) begin
                            r_spline <= 1'b1;
                            r_state  <= S_IDLE;
                        end else begin
                            r_idx <= r_idx - AW'(1);
                        end
                    end else begin
                        r_sub <= r_sub + SUB_W'(1);
                    end
                end
                S_EV: begin
                    if (r_sub == SUB_EV_FIN) begin
                        r_sub   <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_sub <= r_sub + SUB_W'(1);
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out.status <= r_stat;
                        r_out.out_x  <= (r_stat == ncs_pkg::ST_OK) ? w_res_x : '0;
                        r_out.out_y  <= (r_stat == ncs_pkg::ST_OK) ? w_res_y : '0;
                        r_out.out_z  <= (r_stat == ncs_pkg::ST_OK) ? w_res_z : '0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule
`default_nettype wire
